[hw/rtl/icr_pkg.sv]
package icr_pkg;

  // Fixed field widths of the request and result channels
  localparam int unsigned OP_W      = 2;
  localparam int unsigned ID_FW     = 8;
  localparam int unsigned LEN_FW    = 16;
  localparam int unsigned SLOT_FW   = 6;
  localparam int unsigned STATUS_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_QUERY   = 2'd0,
    OP_RESERVE = 2'd1,
    OP_RELEASE = 2'd2,
    OP_SPARE   = 2'd3
  } op_e_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_ROOM   = 3'd1,
    ST_HELD      = 3'd2,
    ST_NOT_HELD  = 3'd3,
    ST_BAD_RANGE = 3'd4
  } status_e_t;

  typedef enum logic [2:0] {
    S_CLEAR  = 3'd0,
    S_IDLE   = 3'd1,
    S_WALK   = 3'd2,
    S_LOOKUP = 3'd3,
    S_DECIDE = 3'd4
  } state_e_t;

  // Broadcast from the controller to every cell of the slot chain
  typedef struct packed {
    logic [SLOT_FW-1:0] lo;
    logic [SLOT_FW-1:0] hi;
    logic               commit;
    logic               do_sub;
  } cell_ctl_t;

endpackage

[hw/rtl/interval_capacity_reservation_top.sv]
// A request passes the walk, lookup and decide states before out_valid; client_id is reduced
// modulo NUM_CLIENTS by one subtraction a cycle, and the walk lasts until the reduction is done.
// No new request is taken until its result is loaded into the output register; the fit and cover
// flags ripple one slot cell per cycle down the chain.
// Reset: slot use clears at once; the holder map RAM is cleared entry by entry
// after reset, with in_ready low; cfg_ready is low only while a request is worked.
module interval_capacity_reservation_top import icr_pkg::*; #(
  parameter int unsigned NUM_SLOTS   = 64,
  parameter int unsigned NUM_CLIENTS = 256,
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     in_op,
  input  logic [ID_FW-1:0]    in_client_id,
  input  logic [LEN_FW-1:0]   in_demand_length,
  input  logic [SLOT_FW-1:0]  in_first_slot,
  input  logic [SLOT_FW-1:0]  in_last_slot,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_fits,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_held,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [LEN_FW-1:0]   cfg_data
);

  localparam int unsigned ID_W  = $clog2(NUM_CLIENTS);
  localparam int unsigned CNT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_SLOTS - 1);
  localparam logic [ID_W-1:0]  CLR_LAST = ID_W'(NUM_CLIENTS - 1);

  state_e_t               state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [ID_W-1:0]        clr_r, clr_nxt;
  logic [ID_FW-1:0]       id_r, id_nxt;
  op_e_t                  op_r;
  logic [LENGTH_BITS-1:0] need_r;
  logic [SLOT_FW-1:0]     lo_r;
  logic [SLOT_FW-1:0]     hi_r;
  logic [LENGTH_BITS-1:0] section_r;

  logic                   out_valid_r;
  logic                   out_fits_r;
  status_e_t              out_status_r;
  logic                   out_held_r;
  logic                   out_fits_nxt;
  status_e_t              out_status_nxt;
  logic                   out_held_nxt;

  logic                   in_xfer;
  logic                   out_free;
  logic                   load_out;
  logic                   id_big;
  logic                   bad_range;
  logic                   fits;
  logic                   commit;

  logic [NUM_SLOTS:0]     fit_chain;
  logic [NUM_SLOTS:0]     cov_chain;
  cell_ctl_t              cell_ctl;

  logic                   ram_we;
  logic [ID_W-1:0]        ram_waddr;
  logic                   ram_wdata;
  logic [ID_W-1:0]        ram_addr;
  logic                   held_now;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = (state_r == S_IDLE) || (state_r == S_CLEAR);
  assign out_free  = !out_valid_r || out_ready;
  assign id_big    = (32'(id_r) >= 32'(NUM_CLIENTS));
  assign ram_addr  = ID_W'(id_r);

  // Hold the capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      section_r <= LENGTH_BITS'(16'hFFFF);
    end else if (cfg_valid && cfg_ready) begin
      section_r <= LENGTH_BITS'(cfg_data);
    end
  end

  // Capture the request on transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r   <= op_e_t'(in_op);
      need_r <= LENGTH_BITS'(in_demand_length);
      lo_r   <= in_first_slot;
      hi_r   <= in_last_slot;
    end
  end

  // Decide the result from the chain flags and the holder bit
  always_comb begin
    bad_range      = (lo_r > hi_r) || (32'(hi_r) >= 32'(NUM_SLOTS));
    fits           = !bad_range && fit_chain[NUM_SLOTS];
    commit         = 1'b0;
    out_fits_nxt   = fits;
    out_held_nxt   = held_now;
    out_status_nxt = fits ? ST_OK : ST_NO_ROOM;
    if (bad_range) begin
      out_status_nxt = ST_BAD_RANGE;
    end else begin
      case (op_r)
        OP_RESERVE: begin
          if (held_now) begin
            out_status_nxt = ST_HELD;
          end else if (!fits) begin
            out_status_nxt = ST_NO_ROOM;
          end else begin
            out_status_nxt = ST_OK;
            commit         = 1'b1;
            out_held_nxt   = 1'b1;
          end
        end
        OP_RELEASE: begin
          if (!held_now || !cov_chain[NUM_SLOTS]) begin
            out_status_nxt = ST_NOT_HELD;
          end else begin
            out_status_nxt = ST_OK;
            commit         = 1'b1;
            out_held_nxt   = 1'b0;
          end
        end
        default: begin
          out_status_nxt = fits ? ST_OK : ST_NO_ROOM;
        end
      endcase
    end
  end

  // Next state, counters and strobes
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    clr_nxt   = clr_r;
    id_nxt    = id_r;
    load_out  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = ram_addr;
    ram_wdata = 1'b0;
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          id_nxt    = in_client_id;
          cnt_nxt   = '0;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        // Reduce the client ID modulo the table size while the flags ripple
        if (id_big) begin
          id_nxt = id_r - ID_FW'(NUM_CLIENTS);
        end
        if (cnt_r != CNT_LAST) begin
          cnt_nxt = cnt_r + 1'b1;
        end else if (!id_big) begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (out_free) begin
          load_out  = 1'b1;
          ram_we    = commit;
          ram_wdata = (op_r == OP_RESERVE);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

  // Output register: load on decide, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_fits_r   <= out_fits_nxt;
      out_status_r <= out_status_nxt;
      out_held_r   <= out_held_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_fits   = out_fits_r;
  assign out_status = out_status_r;
  assign out_held   = out_held_r;

  // Broadcast to the slot cells
  assign cell_ctl.lo     = lo_r;
  assign cell_ctl.hi     = hi_r;
  assign cell_ctl.commit = load_out && commit;
  assign cell_ctl.do_sub = (op_r == OP_RELEASE);

  assign fit_chain[0] = 1'b1;
  assign cov_chain[0] = 1'b1;

  // Chain of slot cells
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    icr_cell #(
      .LENGTH_BITS (LENGTH_BITS),
      .IDX         (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (cell_ctl),
      .need    (need_r),
      .section (section_r),
      .fit_in  (fit_chain[g]),
      .cov_in  (cov_chain[g]),
      .fit_out (fit_chain[g+1]),
      .cov_out (cov_chain[g+1])
    );
  end

  // Holder map
  icr_ram #(
    .WIDTH (1),
    .DEPTH (NUM_CLIENTS)
  ) u_holder (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_addr),
    .rdata (held_now)
  );

  // No request is taken before the holder map is clear
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready)
    else $error("request taken during holder map clear");

  // The walk ends only after every cell has been visited and the ID is reduced
  a_walk_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOKUP) |-> (cnt_r == CNT_LAST) && !id_big)
    else $error("lookup started before walk completed");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !load_out)
    else $error("pending result overwritten");

  // A bad range never reports a fit
  a_bad_range_no_fit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_BAD_RANGE)) |-> !out_fits_r)
    else $error("bad range reported as fitting");

  // A fitting request never reports lack of room
  a_fit_not_no_room: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fits_r) |-> (out_status_r != ST_NO_ROOM))
    else $error("fitting request reported without room");

endmodule

[hw/rtl/icr_ram.sv]
module icr_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/icr_cell.sv]
module icr_cell import icr_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 16,
  parameter int unsigned IDX         = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cell_ctl_t              ctl,
  input  logic [LENGTH_BITS-1:0] need,
  input  logic [LENGTH_BITS-1:0] section,
  input  logic                   fit_in,
  input  logic                   cov_in,
  output logic                   fit_out,
  output logic                   cov_out
);

  localparam logic [31:0] IDX_U = 32'(IDX);

  logic [LENGTH_BITS-1:0] used_r;
  logic [LENGTH_BITS-1:0] used_nxt;
  logic                   fit_r;
  logic                   cov_r;
  logic                   in_range;
  logic [LENGTH_BITS:0]   sum;
  logic                   fit_ok;
  logic                   cov_ok;

  // Decide whether this slot lies in the requested range
  assign in_range = (32'(ctl.lo) <= IDX_U) && (32'(ctl.hi) >= IDX_U);

  // Local checks: room for the demand, and enough use to give back
  assign sum    = {1'b0, used_r} + {1'b0, need};
  assign fit_ok = !in_range || (sum <= {1'b0, section});
  assign cov_ok = !in_range || (used_r >= need);

  // Add or subtract the demand on commit
  always_comb begin
    used_nxt = used_r;
    if (ctl.commit && in_range) begin
      used_nxt = ctl.do_sub ? (used_r - need) : (used_r + need);
    end
  end

  // Hold the slot use and pass the running flags to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      fit_r  <= 1'b1;
      cov_r  <= 1'b1;
    end else begin
      used_r <= used_nxt;
      fit_r  <= fit_in & fit_ok;
      cov_r  <= cov_in & cov_ok;
    end
  end

  assign fit_out = fit_r;
  assign cov_out = cov_r;

endmodule
